### design/ppd_pkg.sv
// Shared types and constants for the primitive pair distance block.
package ppd_pkg;

    localparam logic [1:0] KIND_POINT = 2'd0;
    localparam logic [1:0] KIND_SEG   = 2'd1;
    localparam logic [1:0] KIND_RAY   = 2'd2;
    localparam logic [1:0] KIND_LINE  = 2'd3;

    localparam int N_CAND  = 4;
    // per candidate difference layout: w = P-Q, d = R-Q, v = P-R
    localparam int N_CDIFF = 6;
    localparam int D_WX    = 0;
    localparam int D_WY    = 1;
    localparam int D_DX    = 2;
    localparam int D_DY    = 3;
    localparam int D_VX    = 4;
    localparam int D_VY    = 5;
    // crossing test differences: e1 = B-A, e2 = D-C, e = C-A
    localparam int X_BASE  = N_CAND * N_CDIFF;
    localparam int X_E1X   = 0;
    localparam int X_E1Y   = 1;
    localparam int X_E2X   = 2;
    localparam int X_E2Y   = 3;
    localparam int X_EX    = 4;
    localparam int X_EY    = 5;
    localparam int N_DIFF  = X_BASE + 6;

    localparam int FIFO_AW    = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    typedef struct packed {
        logic [1:0]                k1;
        logic [1:0]                k2;
        logic [N_CAND-1:0]         act;
        logic [N_CAND-1:0][1:0]    kind;
    } t_ctrl;

endpackage

### design/ppd_front.sv
// Front end: degenerate object folding, candidate selection and coordinate differences.
module ppd_front #(
    parameter int COORD_BITS = 21
) (
    input  logic [3:0]                                  i_func,
    input  logic signed [COORD_BITS-1:0]                i_a_x,
    input  logic signed [COORD_BITS-1:0]                i_a_y,
    input  logic signed [COORD_BITS-1:0]                i_b_x,
    input  logic signed [COORD_BITS-1:0]                i_b_y,
    input  logic signed [COORD_BITS-1:0]                i_c_x,
    input  logic signed [COORD_BITS-1:0]                i_c_y,
    input  logic signed [COORD_BITS-1:0]                i_d_x,
    input  logic signed [COORD_BITS-1:0]                i_d_y,
    output ppd_pkg::t_ctrl                              o_ctrl,
    output logic [ppd_pkg::N_DIFF-1:0][COORD_BITS:0]    o_diff
);

    logic [1:0] k1, k2;
    logic [ppd_pkg::N_CAND-1:0][COORD_BITS-1:0] px, py, qx, qy, rx, ry;

    function automatic logic [COORD_BITS:0] sub(input logic [COORD_BITS-1:0] p,
                                                 input logic [COORD_BITS-1:0] q);
        return {p[COORD_BITS-1], p} - {q[COORD_BITS-1], q};
    endfunction

    // candidates: A and B against object CD, C and D against object AB
    assign px = {i_d_x, i_c_x, i_b_x, i_a_x};
    assign py = {i_d_y, i_c_y, i_b_y, i_a_y};
    assign qx = {i_a_x, i_a_x, i_c_x, i_c_x};
    assign qy = {i_a_y, i_a_y, i_c_y, i_c_y};
    assign rx = {i_b_x, i_b_x, i_d_x, i_d_x};
    assign ry = {i_b_y, i_b_y, i_d_y, i_d_y};

    assign k1 = (i_a_x == i_b_x && i_a_y == i_b_y) ? ppd_pkg::KIND_POINT : i_func[3:2];
    assign k2 = (i_c_x == i_d_x && i_c_y == i_d_y) ? ppd_pkg::KIND_POINT : i_func[1:0];

    always_comb begin
        o_ctrl.k1      = k1;
        o_ctrl.k2      = k2;
        // two lines that miss each other fall back to A against line CD
        o_ctrl.act[0]  = (k1 != ppd_pkg::KIND_LINE) || (k2 == ppd_pkg::KIND_LINE);
        o_ctrl.act[1]  = (k1 == ppd_pkg::KIND_SEG);
        o_ctrl.act[2]  = (k2 != ppd_pkg::KIND_LINE);
        o_ctrl.act[3]  = (k2 == ppd_pkg::KIND_SEG);
        o_ctrl.kind[0] = k2;
        o_ctrl.kind[1] = k2;
        o_ctrl.kind[2] = k1;
        o_ctrl.kind[3] = k1;
        for (int c = 0; c < ppd_pkg::N_CAND; c++) begin
            o_diff[c*ppd_pkg::N_CDIFF+ppd_pkg::D_WX] = sub(px[c], qx[c]);
            o_diff[c*ppd_pkg::N_CDIFF+ppd_pkg::D_WY] = sub(py[c], qy[c]);
            o_diff[c*ppd_pkg::N_CDIFF+ppd_pkg::D_DX] = sub(rx[c], qx[c]);
            o_diff[c*ppd_pkg::N_CDIFF+ppd_pkg::D_DY] = sub(ry[c], qy[c]);
            o_diff[c*ppd_pkg::N_CDIFF+ppd_pkg::D_VX] = sub(px[c], rx[c]);
            o_diff[c*ppd_pkg::N_CDIFF+ppd_pkg::D_VY] = sub(py[c], ry[c]);
        end
        o_diff[ppd_pkg::X_BASE+ppd_pkg::X_E1X] = sub(i_b_x, i_a_x);
        o_diff[ppd_pkg::X_BASE+ppd_pkg::X_E1Y] = sub(i_b_y, i_a_y);
        o_diff[ppd_pkg::X_BASE+ppd_pkg::X_E2X] = sub(i_d_x, i_c_x);
        o_diff[ppd_pkg::X_BASE+ppd_pkg::X_E2Y] = sub(i_d_y, i_c_y);
        o_diff[ppd_pkg::X_BASE+ppd_pkg::X_EX]  = sub(i_c_x, i_a_x);
        o_diff[ppd_pkg::X_BASE+ppd_pkg::X_EY]  = sub(i_c_y, i_a_y);
    end

endmodule

### design/ppd_fifo.sv
// Short queue between the front end and the arithmetic back end.
module ppd_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int AW = ppd_pkg::FIFO_AW;

    logic [WIDTH-1:0] r_mem [ppd_pkg::FIFO_DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             wr_ok, rd_ok;

    assign o_full  = (r_cnt == (AW+1)'(ppd_pkg::FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_ok) r_wp <= r_wp + 1'b1;
            if (rd_ok) r_rp <= r_rp + 1'b1;
            if (wr_ok && !rd_ok) r_cnt <= r_cnt + 1'b1;
            else if (rd_ok && !wr_ok) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

### design/ppd_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module ppd_div #(
    parameter int DEN_W = 44,
    parameter int QW    = 76
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [DEN_W-1:0] i_rem,
    input  logic [QW-1:0]    i_x,
    input  logic [DEN_W-1:0] i_den,
    output logic [QW-1:0]    o_q
);

    // i_rem < i_den on entry; i_x holds the low dividend bits and fills with quotient
    logic [DEN_W-1:0] r_rem [1:QW];
    logic [QW-1:0]    r_x   [1:QW];
    logic [DEN_W-1:0] r_den [1:QW];
    logic [DEN_W-1:0] s_rem [0:QW];
    logic [QW-1:0]    s_x   [0:QW];
    logic [DEN_W-1:0] s_den [0:QW];

    assign s_rem[0] = i_rem;
    assign s_x[0]   = i_x;
    assign s_den[0] = i_den;

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [DEN_W:0] t, diff;
        logic           ge;
        assign t    = {s_rem[s], s_x[s][QW-1]};
        assign diff = t - {1'b0, s_den[s]};
        assign ge   = (t >= {1'b0, s_den[s]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
                r_x[s+1]   <= {s_x[s][QW-2:0], ge};
                r_den[s+1] <= s_den[s];
            end
        end

        assign s_rem[s+1] = r_rem[s+1];
        assign s_x[s+1]   = r_x[s+1];
        assign s_den[s+1] = r_den[s+1];
    end

    assign o_q = s_x[QW];

endmodule

### design/ppd_isqrt.sv
// Pipelined integer square root, one root bit per stage.
module ppd_isqrt #(
    parameter int OB = 38
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [2*OB-1:0] i_val,
    output logic [OB-1:0]   o_root
);

    localparam int RW = OB + 2;

    logic [RW-1:0]   r_rem  [1:OB];
    logic [OB-1:0]   r_root [1:OB];
    logic [2*OB-1:0] r_x    [1:OB];
    logic [RW-1:0]   s_rem  [0:OB];
    logic [OB-1:0]   s_root [0:OB];
    logic [2*OB-1:0] s_x    [0:OB];

    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_x[0]    = i_val;

    for (genvar s = 0; s < OB; s++) begin : g_stage
        logic [RW+1:0] t, trial, diff;
        logic          ge;
        assign t     = {s_rem[s], s_x[s][2*OB-1 -: 2]};
        assign trial = (RW+2)'({s_root[s], 2'b01});
        assign diff  = t - trial;
        assign ge    = (t >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1]  <= ge ? diff[RW-1:0] : t[RW-1:0];
                r_root[s+1] <= {s_root[s][OB-2:0], ge};
                r_x[s+1]    <= {s_x[s][2*OB-3:0], 2'b00};
            end
        end

        assign s_rem[s+1]  = r_rem[s+1];
        assign s_root[s+1] = r_root[s+1];
        assign s_x[s+1]    = r_x[s+1];
    end

    assign o_root = s_root[OB];

endmodule

### design/ppd_back.sv
// Back end: products, exact tests, candidate quotients, minimum and square root.
module ppd_back #(
    parameter int COORD_BITS = 21,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    output logic                                        o_take,
    input  ppd_pkg::t_ctrl                              i_ctrl,
    input  logic [ppd_pkg::N_DIFF-1:0][COORD_BITS:0]    i_diff,
    input  logic                                        i_pop,
    output logic                                        o_empty,
    output logic [COORD_BITS+FRAC_BITS:0]               o_distance,
    output logic                                        o_touching
);

    localparam int NC   = ppd_pkg::N_CAND;
    localparam int DW   = COORD_BITS + 1;
    localparam int PW   = 2 * DW;
    localparam int H    = DW;
    localparam int SW   = 2 * PW;
    localparam int OB   = COORD_BITS + FRAC_BITS + 1;
    localparam int QW   = 2 * OB;
    localparam int NWID = SW + 2 * FRAC_BITS;
    localparam int NST  = 7 + QW + OB;
    localparam int TCL  = QW + 2 + OB;

    logic           en;
    logic [NST-1:0] r_vld;

    assign en      = !r_vld[NST-1] || i_pop;
    assign o_take  = en && i_valid;
    assign o_empty = !r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    function automatic logic signed [DW-1:0] dv(input int idx);
        return $signed(i_diff[idx]);
    endfunction

    // stage 1: products
    logic signed [PW-1:0] r1_xx [NC], r1_yy [NC], r1_xy [NC], r1_yx [NC];
    logic signed [PW-1:0] r1_wx2 [NC], r1_wy2 [NC], r1_vx2 [NC], r1_vy2 [NC];
    logic signed [PW-1:0] r1_dx2 [NC], r1_dy2 [NC];
    logic signed [PW-1:0] r1_xp [6];
    ppd_pkg::t_ctrl       r1_ctrl;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < NC; c++) begin
                r1_xx[c]  <= dv(c*ppd_pkg::N_CDIFF+ppd_pkg::D_DX)
                           * dv(c*ppd_pkg::N_CDIFF+ppd_pkg::D_WX);
                r1_yy[c]  <= dv(c*ppd_pkg::N_CDIFF+ppd_pkg::D_DY)
                           * dv(c*ppd_pkg::N_CDIFF+ppd_pkg::D_WY);
                r1_xy[c]  <= dv(c*ppd_pkg::N_CDIFF+ppd_pkg::D_DX)
                           * dv(c*ppd_pkg::N_CDIFF+ppd_pkg::D_WY);
                r1_yx[c]  <= dv(c*ppd_pkg::N_CDIFF+ppd_pkg::D_DY)
                           * dv(c*ppd_pkg::N_CDIFF+ppd_pkg::D_WX);
                r1_wx2[c] <= dv(c*ppd_pkg::N_CDIFF+ppd_pkg::D_WX)
                           * dv(c*ppd_pkg::N_CDIFF+ppd_pkg::D_WX);
                r1_wy2[c] <= dv(c*ppd_pkg::N_CDIFF+ppd_pkg::D_WY)
                           * dv(c*ppd_pkg::N_CDIFF+ppd_pkg::D_WY);
                r1_vx2[c] <= dv(c*ppd_pkg::N_CDIFF+ppd_pkg::D_VX)
                           * dv(c*ppd_pkg::N_CDIFF+ppd_pkg::D_VX);
                r1_vy2[c] <= dv(c*ppd_pkg::N_CDIFF+ppd_pkg::D_VY)
                           * dv(c*ppd_pkg::N_CDIFF+ppd_pkg::D_VY);
                r1_dx2[c] <= dv(c*ppd_pkg::N_CDIFF+ppd_pkg::D_DX)
                           * dv(c*ppd_pkg::N_CDIFF+ppd_pkg::D_DX);
                r1_dy2[c] <= dv(c*ppd_pkg::N_CDIFF+ppd_pkg::D_DY)
                           * dv(c*ppd_pkg::N_CDIFF+ppd_pkg::D_DY);
            end
            r1_xp[0] <= dv(ppd_pkg::X_BASE+ppd_pkg::X_E1X) * dv(ppd_pkg::X_BASE+ppd_pkg::X_E2Y);
            r1_xp[1] <= dv(ppd_pkg::X_BASE+ppd_pkg::X_E1Y) * dv(ppd_pkg::X_BASE+ppd_pkg::X_E2X);
            r1_xp[2] <= dv(ppd_pkg::X_BASE+ppd_pkg::X_EX)  * dv(ppd_pkg::X_BASE+ppd_pkg::X_E2Y);
            r1_xp[3] <= dv(ppd_pkg::X_BASE+ppd_pkg::X_EY)  * dv(ppd_pkg::X_BASE+ppd_pkg::X_E2X);
            r1_xp[4] <= dv(ppd_pkg::X_BASE+ppd_pkg::X_EX)  * dv(ppd_pkg::X_BASE+ppd_pkg::X_E1Y);
            r1_xp[5] <= dv(ppd_pkg::X_BASE+ppd_pkg::X_EY)  * dv(ppd_pkg::X_BASE+ppd_pkg::X_E1X);
            r1_ctrl  <= i_ctrl;
        end
    end

    // stage 2: dot, cross and squared lengths
    logic signed [PW-1:0] r2_dot [NC], r2_cr [NC];
    logic [PW-1:0]        r2_nw [NC], r2_nv [NC], r2_dd [NC];
    logic signed [PW-1:0] r2_den, r2_tn, r2_un;
    ppd_pkg::t_ctrl       r2_ctrl;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < NC; c++) begin
                r2_dot[c] <= r1_xx[c] + r1_yy[c];
                r2_cr[c]  <= r1_xy[c] - r1_yx[c];
                r2_nw[c]  <= r1_wx2[c] + r1_wy2[c];
                r2_nv[c]  <= r1_vx2[c] + r1_vy2[c];
                r2_dd[c]  <= r1_dx2[c] + r1_dy2[c];
            end
            r2_den  <= r1_xp[0] - r1_xp[1];
            r2_tn   <= r1_xp[2] - r1_xp[3];
            r2_un   <= r1_xp[4] - r1_xp[5];
            r2_ctrl <= r1_ctrl;
        end
    end

    // stage 3: pick the nearest feature of each candidate, exact crossing test
    function automatic logic pok(input logic [1:0] k, input logic signed [PW-1:0] n,
                                 input logic signed [PW-1:0] d);
        case (k)
            ppd_pkg::KIND_SEG: return (n >= 0) && (n <= d);
            ppd_pkg::KIND_RAY: return (n >= 0);
            default:           return 1'b1;
        endcase
    endfunction

    logic                 n3_line [NC], n3_zero [NC], dle0 [NC], dge [NC];
    logic [PW-1:0]        n3_val [NC], n3_den [NC];
    logic [NC-1:0]        zmask;
    logic signed [PW-1:0] xden, xtn, xun;
    logic                 n3_cross;

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            dle0[c] = (r2_dot[c] <= 0);
            dge[c]  = ($signed({r2_dot[c][PW-1], r2_dot[c]}) >= $signed({1'b0, r2_dd[c]}));
            if (r2_ctrl.kind[c] == ppd_pkg::KIND_POINT
                || (r2_ctrl.kind[c] != ppd_pkg::KIND_LINE && dle0[c])) begin
                n3_line[c] = 1'b0;
                n3_val[c]  = r2_nw[c];
            end else if (r2_ctrl.kind[c] == ppd_pkg::KIND_SEG && dge[c]) begin
                n3_line[c] = 1'b0;
                n3_val[c]  = r2_nv[c];
            end else begin
                n3_line[c] = 1'b1;
                n3_val[c]  = r2_cr[c][PW-1] ? (~r2_cr[c] + 1'b1) : r2_cr[c];
            end
            n3_den[c]  = n3_line[c] ? r2_dd[c] : PW'(1);
            n3_zero[c] = (n3_val[c] == '0);
            zmask[c]   = n3_zero[c] && r2_ctrl.act[c];
        end
        xden = r2_den;
        xtn  = r2_tn;
        xun  = r2_un;
        if (r2_den < 0) begin
            xden = -r2_den;
            xtn  = -r2_tn;
            xun  = -r2_un;
        end
        n3_cross = (r2_ctrl.k1 != ppd_pkg::KIND_POINT) && (r2_ctrl.k2 != ppd_pkg::KIND_POINT)
                 && (r2_den != 0) && pok(r2_ctrl.k1, xtn, xden)
                 && pok(r2_ctrl.k2, xun, xden);
    end

    logic          r3_line [NC];
    logic [PW-1:0] r3_val [NC], r3_den [NC];
    logic [NC-1:0] r3_act;
    logic [1:0]    r3_tc;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < NC; c++) begin
                r3_line[c] <= n3_line[c];
                r3_val[c]  <= n3_val[c];
                r3_den[c]  <= n3_den[c];
            end
            r3_act <= r2_ctrl.act;
            r3_tc  <= {n3_cross || (zmask != '0), n3_cross};
        end
    end

    // stage 4: square of the cross magnitude in half-width partial products
    logic          r4_line [NC];
    logic [PW-1:0] r4_val [NC], r4_den [NC], r4_hh [NC], r4_hl [NC], r4_ll [NC];
    logic [NC-1:0] r4_act;
    logic [1:0]    r4_tc;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < NC; c++) begin
                r4_hh[c]   <= r3_val[c][PW-1:H] * r3_val[c][PW-1:H];
                r4_hl[c]   <= r3_val[c][PW-1:H] * r3_val[c][H-1:0];
                r4_ll[c]   <= r3_val[c][H-1:0] * r3_val[c][H-1:0];
                r4_line[c] <= r3_line[c];
                r4_val[c]  <= r3_val[c];
                r4_den[c]  <= r3_den[c];
            end
            r4_act <= r3_act;
            r4_tc  <= r3_tc;
        end
    end

    // stage 5: scaled numerator, split into divider start remainder and low bits
    logic [SW-1:0]   n5_sq  [NC];
    logic [NWID-1:0] n5_num [NC];
    logic [PW-1:0]   r5_rem [NC], r5_den [NC];
    logic [QW-1:0]   r5_x [NC];
    logic [NC-1:0]   r5_act;
    logic [1:0]      r5_tc;

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            n5_sq[c]  = (SW'(r4_hh[c]) << (2*H)) + (SW'(r4_hl[c]) << (H+1)) + SW'(r4_ll[c]);
            n5_num[c] = (r4_line[c] ? NWID'(n5_sq[c]) : NWID'(r4_val[c])) << (2*FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < NC; c++) begin
                r5_rem[c] <= n5_num[c][NWID-1:QW];
                r5_x[c]   <= n5_num[c][QW-1:0];
                r5_den[c] <= r4_den[c];
            end
            r5_act <= r4_act;
            r5_tc  <= r4_tc;
        end
    end

    // quotients, one divider per candidate
    logic [QW-1:0] q [NC];

    for (genvar c = 0; c < NC; c++) begin : g_div
        ppd_div #(.DEN_W(PW), .QW(QW)) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_rem (r5_rem[c]),
            .i_x   (r5_x[c]),
            .i_den (r5_den[c]),
            .o_q   (q[c])
        );
    end

    logic [NC-1:0] r_actd [1:QW];
    logic [1:0]    r_tcd  [1:TCL];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_actd[1] <= r5_act;
            for (int k = 1; k < QW; k++) r_actd[k+1] <= r_actd[k];
            r_tcd[1] <= r5_tc;
            for (int k = 1; k < TCL; k++) r_tcd[k+1] <= r_tcd[k];
        end
    end

    // minimum over active candidates; floor and root are monotone so order holds
    function automatic logic [QW:0] min2(input logic [QW-1:0] qa, input logic aa,
                                         input logic [QW-1:0] qb, input logic ab);
        if (!ab) return {aa, qa};
        if (!aa) return {ab, qb};
        return (qb < qa) ? {1'b1, qb} : {1'b1, qa};
    endfunction

    logic [QW:0]   r6_m [2];
    logic [QW-1:0] r7_q;
    logic [QW:0]   n7_m;

    assign n7_m = min2(r6_m[0][QW-1:0], r6_m[0][QW], r6_m[1][QW-1:0], r6_m[1][QW]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_m[0] <= min2(q[0], r_actd[QW][0], q[1], r_actd[QW][1]);
            r6_m[1] <= min2(q[2], r_actd[QW][2], q[3], r_actd[QW][3]);
            r7_q    <= n7_m[QW-1:0];
        end
    end

    logic [OB-1:0] root;

    ppd_isqrt #(.OB(OB)) u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (r7_q),
        .o_root (root)
    );

    assign o_distance = r_tcd[TCL][0] ? '0 : root;
    assign o_touching = r_tcd[TCL][1];

endmodule

### design/primitive_pair_distance.sv
// Distance between two planar primitives (point, segment, ray or line).
//
// Input queue: drive push with func and the four points A, B, C, D; a transfer
// happens on a clock edge with push high and full low. func = 4*kind1 + kind2
// (0 point, 1 segment, 2 ray, 3 line); a degenerate object counts as a point.
// Result queue: while empty is low the oldest result sits on o_distance_q16
// (unsigned, FRAC_BITS fraction bits, rounded down) and o_touching; a transfer
// happens on an edge with pop high and empty low.
// From input transfer to result, the quotient pipeline takes one bit per
// stage over 2*(COORD_BITS+FRAC_BITS+1) stages and the square root one bit
// per stage after it. One item per cycle is sustained while pop keeps pace
// with the results.
// When pop stays low with a result waiting, the back end pipeline holds; the
// four-entry queue behind the front end keeps taking items until it fills,
// and full then stays high until results are taken again.
// A synchronous reset (i_rst_n low) empties the queue and the pipeline.
module primitive_pair_distance #(
    parameter int COORD_BITS = 21,
    parameter int FRAC_BITS  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [3:0]                      i_func,
    input  logic signed [COORD_BITS-1:0]    i_a_x,
    input  logic signed [COORD_BITS-1:0]    i_a_y,
    input  logic signed [COORD_BITS-1:0]    i_b_x,
    input  logic signed [COORD_BITS-1:0]    i_b_y,
    input  logic signed [COORD_BITS-1:0]    i_c_x,
    input  logic signed [COORD_BITS-1:0]    i_c_y,
    input  logic signed [COORD_BITS-1:0]    i_d_x,
    input  logic signed [COORD_BITS-1:0]    i_d_y,
    output logic                            empty,
    input  logic                            pop,
    output logic [COORD_BITS+FRAC_BITS:0]   o_distance_q16,
    output logic                            o_touching
);

    localparam int DIFF_W = ppd_pkg::N_DIFF * (COORD_BITS + 1);
    localparam int ITEM_W = $bits(ppd_pkg::t_ctrl) + DIFF_W;

    ppd_pkg::t_ctrl                             f_ctrl, b_ctrl;
    logic [ppd_pkg::N_DIFF-1:0][COORD_BITS:0]   f_diff, b_diff;
    logic [ITEM_W-1:0]                          q_rdata;
    logic                                       q_empty, b_take;

    ppd_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_func (i_func),
        .i_a_x  (i_a_x),
        .i_a_y  (i_a_y),
        .i_b_x  (i_b_x),
        .i_b_y  (i_b_y),
        .i_c_x  (i_c_x),
        .i_c_y  (i_c_y),
        .i_d_x  (i_d_x),
        .i_d_y  (i_d_y),
        .o_ctrl (f_ctrl),
        .o_diff (f_diff)
    );

    ppd_fifo #(.WIDTH(ITEM_W)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_wdata ({f_ctrl, f_diff}),
        .o_full  (full),
        .i_rd    (b_take),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    assign b_ctrl = q_rdata[ITEM_W-1:DIFF_W];
    assign b_diff = q_rdata[DIFF_W-1:0];

    ppd_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (!q_empty),
        .o_take     (b_take),
        .i_ctrl     (b_ctrl),
        .i_diff     (b_diff),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_distance (o_distance_q16),
        .o_touching (o_touching)
    );

endmodule
